[rtl/rmns_pkg.sv]
`default_nettype none
package rmns_pkg;

  // fixed field widths
  localparam int CNT_W      = 11;
  localparam int WORD_W     = 32;
  localparam int PICK_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int EPOCH_BITS = 8;

  // default sizing
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int WORD_BITS_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_N_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_M_PICK  = 1'b1;

  localparam logic [CNT_W-1:0] N_TOTAL_RST = 11'd1024;
  localparam logic [CNT_W-1:0] M_PICK_RST  = 11'd0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_M_GT_N   = 2'd1,
    ST_DONE_ALL = 2'd2
  } status_t;

  // request to the serial modulo unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

endpackage
`default_nettype wire

[rtl/rmns_if.sv]
`default_nettype none
interface rmns_in_if;
  logic                      valid;
  logic                      ready;
  logic                      first;
  logic [rmns_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output first, output random_word, input ready);
  modport sink   (input valid, input first, input random_word, output ready);
endinterface

interface rmns_out_if;
  logic                        valid;
  logic                        ready;
  logic [rmns_pkg::PICK_W-1:0] picked;
  logic                        last;
  rmns_pkg::status_t           status;

  modport source (output valid, output picked, output last, output status, input ready);
  modport sink   (input valid, input picked, input last, input status, output ready);
endinterface
`default_nettype wire

[rtl/rmns_ram.sv]
`default_nettype none
module rmns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[rtl/rmns_mod_serial.sv]
`default_nettype none
module rmns_mod_serial #(
  parameter int WORD_BITS = rmns_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rmns_pkg::mod_req_t           req,
  input  wire logic [WORD_BITS-1:0]         dividend,
  output logic                              done,
  output logic [rmns_pkg::CNT_W-1:0]        remainder
);
  import rmns_pkg::*;

  localparam int STEP_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] word_sr_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     div_r;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       rem_nxt;

  // one restoring step per cycle, msb first
  always_comb begin
    trial = {rem_r, word_sr_r[WORD_BITS-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial - {1'b0, div_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(WORD_BITS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      word_sr_r <= dividend;
      rem_r     <= '0;
      div_r     <= req.divisor;
    end else if (busy_r) begin
      word_sr_r <= {word_sr_r[WORD_BITS-2:0], 1'b0};
      rem_r     <= rem_nxt[CNT_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[rtl/random_m_of_n_selector_unit.sv]
`default_nettype none
// Random m-of-n selector: a partial Fisher-Yates shuffle that hands out one distinct
// index of 0..n_total-1 per input beat, using the beat's random word modulo the
// remaining count. A beat with first set starts a new selection. A drawing beat is
// accepted, then starts the bit-serial modulo unit, which runs WORD_BITS restoring
// steps (one remainder bit per cycle); once the unit's done flag is seen, the
// permutation RAM reads slot i, reads slot j, writes i and writes j, and the result
// is loaded into the output register. An error beat (m above n, or selection
// complete) skips the modulo unit and the RAM. Either kind waits while the output
// register still holds an untaken result. Slots are tagged with a selection epoch
// so a new selection needs no clearing; after reset, and on every new selection
// that wraps the 8-bit epoch (once in 255), a clearing pass over all MAX_ITEMS slots
// runs before the draw, during which no beat is accepted but configuration writes
// are still taken. Results go through an output register, so a new beat is
// accepted while the previous result waits.
module random_m_of_n_selector_unit #(
  parameter int MAX_ITEMS = rmns_pkg::MAX_ITEMS_DEF,
  parameter int WORD_BITS = rmns_pkg::WORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rmns_in_if.sink                              in_ch,
  rmns_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rmns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rmns_pkg::CNT_W-1:0]      cfg_wdata
);
  import rmns_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int MEM_W  = EPOCH_BITS + IDX_W;
  // usable count: n_total capped by the table size
  localparam int NCAP   = (MAX_ITEMS > 2047) ? 2047 : MAX_ITEMS;
  localparam logic [CNT_W-1:0]      NCAP_C    = CNT_W'(NCAP);
  localparam logic [IDX_W-1:0]      LAST_SLOT = IDX_W'(MAX_ITEMS - 1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_RDA, S_RDB, S_WRA, S_WRB, S_DONE
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      n_total_r;
  logic [CNT_W-1:0]      m_pick_r;
  logic [CNT_W-1:0]      draw_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic [IDX_W-1:0]      clr_cnt_r;
  logic                  ret_r;        // clearing pass was entered from a beat
  logic [WORD_BITS-1:0]  word_r;
  logic [CNT_W-1:0]      i_r;
  logic [CNT_W-1:0]      div_r;
  status_t               status_r;
  logic [IDX_W-1:0]      a_r;
  logic [IDX_W-1:0]      b_r;
  logic                  mod_start_r;
  logic                  out_valid_r;
  logic [PICK_W-1:0]     out_picked_r;
  logic                  out_last_r;
  status_t               out_status_r;

  logic [CNT_W-1:0]      n_eff;
  logic [CNT_W-1:0]      draw_eff;
  status_t               status_nxt;
  logic                  accept;
  mod_req_t              mod_req;
  logic                  mod_done;
  logic [CNT_W-1:0]      mod_rem;
  logic [CNT_W-1:0]      j_cnt;
  logic [IDX_W-1:0]      i_addr;
  logic [IDX_W-1:0]      j_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [MEM_W-1:0]      mem_rdata;
  logic [IDX_W-1:0]      rd_val;

  // slot content: stored value if tagged with this epoch, else the identity
  function automatic logic [IDX_W-1:0] slot_decode(
    input logic [MEM_W-1:0]      ent,
    input logic [EPOCH_BITS-1:0] ep,
    input logic [IDX_W-1:0]      slot
  );
    if (ent[MEM_W-1:IDX_W] == ep) begin
      return ent[IDX_W-1:0];
    end
    return slot;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // error checks on the current registers, after the effect of first
  always_comb begin
    n_eff    = (n_total_r > NCAP_C) ? NCAP_C : n_total_r;
    draw_eff = in_ch.first ? '0 : draw_r;
    if (m_pick_r > n_eff) begin
      status_nxt = ST_M_GT_N;
    end else if (draw_eff >= m_pick_r) begin
      status_nxt = ST_DONE_ALL;
    end else begin
      status_nxt = ST_OK;
    end
  end

  assign mod_req.start   = mod_start_r;
  assign mod_req.divisor = div_r;

  rmns_mod_serial #(
    .WORD_BITS (WORD_BITS)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mod_req),
    .dividend  (word_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // swap partner: j = i + (word mod (n - i)), always below n
  assign j_cnt  = i_r + mod_rem;
  assign i_addr = IDX_W'(i_r);
  assign j_addr = IDX_W'(j_cnt);

  // read data belongs to the address issued in the previous state
  assign rd_val = slot_decode(mem_rdata, epoch_r, (state_r == S_WRA) ? j_addr : i_addr);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_addr;
    mem_wdata = {epoch_r, rd_val};
    mem_raddr = i_addr;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_RDB: begin
        mem_raddr = j_addr;
      end
      S_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = i_addr;
        mem_wdata = {epoch_r, rd_val};
      end
      S_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = j_addr;
        mem_wdata = {epoch_r, a_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  rmns_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ITEMS)
  ) u_perm (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      n_total_r   <= N_TOTAL_RST;
      m_pick_r    <= M_PICK_RST;
      draw_r      <= '0;
      epoch_r     <= EPOCH_ONE;
      clr_cnt_r   <= '0;
      ret_r       <= 1'b0;
      mod_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mod_start_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_N_TOTAL: n_total_r <= cfg_wdata;
          CFG_M_PICK:  m_pick_r  <= cfg_wdata;
          default:     n_total_r <= n_total_r;
        endcase
      end

      // result taken
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_SLOT) begin
            if (!ret_r) begin
              state_r <= S_IDLE;
            end else if (status_r != ST_OK) begin
              state_r <= S_DONE;
            end else begin
              state_r     <= S_DIV;
              mod_start_r <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            word_r   <= WORD_BITS'(in_ch.random_word);
            i_r      <= draw_eff;
            div_r    <= n_eff - draw_eff;
            status_r <= status_nxt;
            if (in_ch.first) begin
              draw_r <= '0;
            end
            if (in_ch.first && (epoch_r == EPOCH_MAX)) begin
              // epoch wraps: wipe all tags first
              epoch_r   <= EPOCH_ONE;
              clr_cnt_r <= '0;
              ret_r     <= 1'b1;
              state_r   <= S_CLEAR;
            end else begin
              if (in_ch.first) begin
                epoch_r <= epoch_r + 1'b1;
              end
              if (status_nxt != ST_OK) begin
                state_r <= S_DONE;
              end else begin
                state_r     <= S_DIV;
                mod_start_r <= 1'b1;
              end
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            state_r <= S_RDA;
          end
        end
        S_RDA: begin
          state_r <= S_RDB;
        end
        S_RDB: begin
          a_r     <= rd_val;
          state_r <= S_WRA;
        end
        S_WRA: begin
          b_r     <= rd_val;
          state_r <= S_WRB;
        end
        S_WRB: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            if (status_r == ST_OK) begin
              out_picked_r <= PICK_W'(b_r);
              out_last_r   <= ((draw_r + 1'b1) == m_pick_r);
              draw_r       <= draw_r + 1'b1;
            end else begin
              out_picked_r <= '0;
              out_last_r   <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.picked = out_picked_r;
  assign out_ch.last   = out_last_r;
  assign out_ch.status = out_status_r;

endmodule
`default_nettype wire

[rtl/rmns_checker.sv]
`default_nettype none
module rmns_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rmns_pkg::PICK_W-1:0]   out_picked,
  input wire logic                          out_last,
  input wire logic [1:0]                    out_status
);
  import rmns_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // error results carry no pick
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_M_GT_N || out_status == ST_DONE_ALL)
      |-> out_picked == '0 && !out_last)
    else $error("error result with pick fields set");

  // no status code above selection complete
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("unknown status code");

  // one beat in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while the previous one is in work");

endmodule

bind random_m_of_n_selector_unit rmns_checker u_rmns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_picked (out_ch.picked),
  .out_last   (out_ch.last),
  .out_status (out_ch.status)
);
`default_nettype wire
